/* rtl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg: shared types and constants for the ordered array list
// Field widths, operation and status codes, controller states and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

  localparam int OAL_DEPTH = 64;

  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_SEARCH   = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_INS_HEAD = 3'd3,
    OP_INS_TAIL = 3'd4,
    OP_REMOVE   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SRCH,
    S_SHIFT_UP,
    S_INS_WR,
    S_RM_WAIT,
    S_SHIFT_DN,
    S_DONE
  } state_t;

  // Next value of the entry pointer; the memory is always read at that value.
  typedef enum logic [2:0] {
    P_HOLD,
    P_POS,
    P_ZERO,
    P_INC,
    P_DEC,
    P_LAST
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_NEW
  } wr_op_t;

  typedef struct packed {
    logic    load_item;
    ptr_op_t ptr_op;
    wr_op_t  wr_op;
    logic    set_status;
    status_t status;
    logic    cap_data;
    logic    cap_found;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            pos_lt_cnt;
    logic            pos_le_cnt;
    logic            tgt_at_end;
    logic            key_match;
    logic            ptr_last;
    logic            ptr_at_tgt;
    logic            out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/oal_in_if.sv */
// ----------------------------------------------------------------------------
// oal_in_if: operation channel
// Valid/ready channel that carries one list operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_in_if;
  import oal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [POS_W-1:0]        position;
  logic signed [KEY_W-1:0] key_in;
  logic signed [VAL_W-1:0] value_in;

  modport source (output valid, output op, output position, output key_in,
                  output value_in, input ready);
  modport sink   (input valid, input op, input position, input key_in,
                  input value_in, output ready);
endinterface

`default_nettype wire

/* rtl/oal_out_if.sv */
// ----------------------------------------------------------------------------
// oal_out_if: result channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_out_if;
  import oal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [FOUND_W-1:0]      found_position;
  logic signed [KEY_W-1:0] key_out;
  logic signed [VAL_W-1:0] value_out;
  logic [COUNT_W-1:0]      entry_count;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, output status, output found_position,
                  output key_out, output value_out, output entry_count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input found_position,
                  input key_out, input value_out, input entry_count,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

/* rtl/oal_ram.sv */
// ----------------------------------------------------------------------------
// oal_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/oal_datapath.sv */
// ----------------------------------------------------------------------------
// oal_datapath: entry storage, pointer, count and result registers
// Holds the current operation, walks the entry memory under controller
// command and keeps the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_datapath import oal_pkg::*; #(
  parameter int DEPTH = OAL_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  output dp_status_t                   sts,
  input  wire logic [OP_W-1:0]         in_op,
  input  wire logic [POS_W-1:0]        in_position,
  input  wire logic signed [KEY_W-1:0] in_key,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic [STATUS_W-1:0]          out_status,
  output logic [FOUND_W-1:0]           out_found,
  output logic signed [KEY_W-1:0]      out_key,
  output logic signed [VAL_W-1:0]      out_value,
  output logic [COUNT_W-1:0]           out_count,
  output logic                         out_empty,
  output logic                         out_full
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = POS_W + CW;
  localparam int EW   = KEY_W + VAL_W;

  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    count_r;
  status_t          st_r;
  logic [AW-1:0]    fnd_r;
  logic [KEY_W-1:0] kout_r;
  logic [VAL_W-1:0] vout_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FOUND_W-1:0]  out_found_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [VAL_W-1:0]    out_value_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_empty_r;
  logic                out_full_r;

  logic [CMPW-1:0] pos_cmp, cnt_cmp, ptr_cmp, tgt_cmp;
  logic [CW-1:0]   cnt_m1;
  logic [AW+FOUND_W-1:0] fnd_ext;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic            full, empty, out_free;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] rd_data;

  assign pos_cmp = {{CW{1'b0}}, pos_r};
  assign cnt_cmp = {{POS_W{1'b0}}, count_r};
  assign ptr_cmp = {{(CMPW-AW){1'b0}}, ptr_r};
  assign cnt_m1  = count_r - CW'(1);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign out_free = !out_valid_r || out_ready;

  // Position that an insert lands on.
  always_comb begin
    if (op_r == OP_INS_HEAD) begin
      tgt_cmp = '0;
    end else if (op_r == OP_INS_TAIL) begin
      tgt_cmp = cnt_cmp;
    end else begin
      tgt_cmp = pos_cmp;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.full       = full;
    sts.empty      = empty;
    sts.pos_lt_cnt = (pos_cmp < cnt_cmp);
    sts.pos_le_cnt = (pos_cmp <= cnt_cmp);
    sts.tgt_at_end = (tgt_cmp == cnt_cmp);
    sts.key_match  = (rd_data[EW-1:VAL_W] == key_r);
    sts.ptr_last   = ((ptr_cmp + CMPW'(1)) == cnt_cmp);
    sts.ptr_at_tgt = (ptr_cmp == tgt_cmp);
    sts.out_free   = out_free;
  end

  always_comb begin
    unique case (cmd.ptr_op)
      P_HOLD:  ptr_nxt = ptr_r;
      P_POS:   ptr_nxt = pos_cmp[AW-1:0];
      P_ZERO:  ptr_nxt = '0;
      P_INC:   ptr_nxt = ptr_r + AW'(1);
      P_DEC:   ptr_nxt = ptr_r - AW'(1);
      P_LAST:  ptr_nxt = cnt_m1[AW-1:0];
      default: ptr_nxt = ptr_r;
    endcase
  end

  // The memory is read at ptr_nxt, so the registered read data holds the entry at the pointer.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = rd_data;
    unique case (cmd.wr_op)
      WR_NONE: wr_en = 1'b0;
      WR_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r + AW'(1);
      end
      WR_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r - AW'(1);
      end
      WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = tgt_cmp[AW-1:0];
        wr_data = {key_r, val_r};
      end
      default: wr_en = 1'b0;
    endcase
  end

  oal_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_nxt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load_item) begin
      op_r   <= in_op;
      pos_r  <= in_position;
      key_r  <= in_key;
      val_r  <= in_value;
      st_r   <= ST_OK;
      fnd_r  <= '0;
      kout_r <= '0;
      vout_r <= '0;
    end else begin
      if (cmd.set_status) begin
        st_r <= cmd.status;
      end
      if (cmd.cap_data) begin
        kout_r <= rd_data[EW-1:VAL_W];
        vout_r <= rd_data[VAL_W-1:0];
      end
      if (cmd.cap_found) begin
        fnd_r <= ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= cnt_m1;
    end
  end

  assign fnd_ext = {{FOUND_W{1'b0}}, fnd_r};
  assign cnt_ext = {{COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_found_r  <= fnd_ext[FOUND_W-1:0];
      out_key_r    <= kout_r;
      out_value_r  <= vout_r;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
      out_empty_r  <= empty;
      out_full_r   <= full;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_key    = out_key_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;
  assign out_empty  = out_empty_r;
  assign out_full   = out_full_r;

endmodule

`default_nettype wire

/* rtl/oal_ctrl.sv */
// ----------------------------------------------------------------------------
// oal_ctrl: operation sequencer
// Decodes each operation and steps the datapath through reads, searches
// and the one-entry-per-cycle shifts of inserts and removes.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_ctrl import oal_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.ptr_op     = P_HOLD;
    cmd.wr_op      = WR_NONE;
    cmd.status     = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt      = S_DONE;
        cmd.set_status = 1'b1;
        cmd.status     = ST_BAD_INDEX;
        unique case (sts.op)
          OP_READ: begin
            if (sts.pos_lt_cnt) begin
              cmd.set_status = 1'b0;
              cmd.ptr_op     = P_POS;
              state_nxt      = S_RD_WAIT;
            end
          end
          OP_SEARCH: begin
            if (sts.empty) begin
              cmd.status = ST_NOT_FOUND;
            end else begin
              cmd.set_status = 1'b0;
              cmd.ptr_op     = P_ZERO;
              state_nxt      = S_SRCH;
            end
          end
          OP_INS_POS, OP_INS_HEAD, OP_INS_TAIL: begin
            priority if (sts.full) begin
              cmd.status = ST_FULL;
            end else if (sts.op == OP_INS_POS && !sts.pos_le_cnt) begin
              cmd.status = ST_BAD_INDEX;
            end else if (sts.tgt_at_end) begin
              cmd.set_status = 1'b0;
              state_nxt      = S_INS_WR;
            end else begin
              // Shift from the last entry down to the insert position.
              cmd.set_status = 1'b0;
              cmd.ptr_op     = P_LAST;
              state_nxt      = S_SHIFT_UP;
            end
          end
          OP_REMOVE: begin
            priority if (sts.empty) begin
              cmd.status = ST_EMPTY;
            end else if (!sts.pos_lt_cnt) begin
              cmd.status = ST_BAD_INDEX;
            end else begin
              cmd.set_status = 1'b0;
              cmd.ptr_op     = P_POS;
              state_nxt      = S_RM_WAIT;
            end
          end
          default: begin
            cmd.status = ST_BAD_INDEX;
          end
        endcase
      end

      S_RD_WAIT: begin
        cmd.cap_data = 1'b1;
        state_nxt    = S_DONE;
      end

      S_SRCH: begin
        priority if (sts.key_match) begin
          cmd.cap_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.ptr_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          cmd.ptr_op = P_INC;
        end
      end

      S_SHIFT_UP: begin
        cmd.wr_op = WR_UP;
        if (sts.ptr_at_tgt) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.ptr_op = P_DEC;
        end
      end

      S_INS_WR: begin
        cmd.wr_op   = WR_NEW;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end

      S_RM_WAIT: begin
        cmd.cap_data = 1'b1;
        if (sts.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.ptr_op = P_INC;
          state_nxt  = S_SHIFT_DN;
        end
      end

      S_SHIFT_DN: begin
        cmd.wr_op = WR_DOWN;
        if (sts.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.ptr_op = P_INC;
        end
      end

      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ordered_array_list_core.sv */
// From an accepted operation, S_DECODE sends a refused one straight to S_DONE, a read to S_RD_WAIT,
// a search through S_SRCH, an insert at the end to S_INS_WR, an insert that shifts through S_SHIFT_UP
// then S_INS_WR, and a remove to S_RM_WAIT then, unless it took the last entry, S_SHIFT_DN. S_DONE
// registers the result when the output is free; the next operation is accepted only after that.
// Shifts and searches move one entry per cycle through the single write port and
// registered read port of the entry memory. Reset empties the list; the memory is not cleared.
// ----------------------------------------------------------------------------
// ordered_array_list_core: ordered key/value list
// Read, search, insert at position, head or tail, and remove, with status,
// entry count and empty and full flags on every result.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_core import oal_pkg::*; #(
  parameter int DEPTH = OAL_DEPTH
) (
  input wire logic clk,
  input wire logic rst_n,
  oal_in_if.sink   in_ch,
  oal_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  oal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oal_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_ch.op),
    .in_position (in_ch.position),
    .in_key      (in_ch.key_in),
    .in_value    (in_ch.value_in),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_found   (out_ch.found_position),
    .out_key     (out_ch.key_out),
    .out_value   (out_ch.value_out),
    .out_count   (out_ch.entry_count),
    .out_empty   (out_ch.is_empty),
    .out_full    (out_ch.is_full)
  );

  // The entry count never grows past a full list nor drops below empty.
  a_no_inc_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("entry count incremented on a full list");

  a_no_dec_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.empty)
    else $error("entry count decremented on an empty list");

  // The entry memory is only written while an operation is in progress.
  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_op != WR_NONE) |-> !in_ch.ready)
    else $error("entry memory written while idle");

  // A result is never loaded over one that has not been taken.
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten before its transaction");

endmodule

`default_nettype wire

/* verif/tb_ordered_array_list_core.sv */
// ----------------------------------------------------------------------------
// tb_ordered_array_list_core: self-checking bench for the ordered array list
// A short table of directed operations walks the empty list, the extreme keys
// and values, every error status except full and the unused op codes. Random
// phases then fill the list to capacity, drain it and mix traffic in between.
// A queue model predicts each result that the table does not give, and both
// channel sides stall at random.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_core;
  import oal_pkg::*;

  localparam int LIST_DEPTH    = OAL_DEPTH;
  localparam int STALL_MAX     = 18;
  localparam int IDLE_LIMIT    = 1000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_OPS    = 1620;
  localparam int DIRECTED_ROWS = 23;
  localparam int POS_SPAN      = (1 << POS_W) - 1;

  localparam logic [OP_W-1:0]  OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0]  OP_UNUSED_7 = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MAX     = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_MIN     = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_ONES    = 32'hFFFF_FFFF;

  typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} traffic_phase_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    status_t            status;
    logic [FOUND_W-1:0] found;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } list_result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } list_entry_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    list_result_t     want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  oal_in_if  op_ch ();
  oal_out_if res_ch ();

  ordered_array_list_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (op_ch),
    .out_ch(res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  list_entry_t   list_model [$];
  list_result_t  predicted_results [$];
  directed_row_t directed_rows [DIRECTED_ROWS];

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int full_results    = 0;
  int full_refusals   = 0;
  int empty_refusals  = 0;
  int quiet_cycles    = 0;
  int send_quiet      = 0;
  int recv_quiet      = 0;

  // Mostly a random wait, but now and then a run of back-to-back transactions.
  function automatic int draw_wait(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 40);
    return $urandom_range(0, STALL_MAX);
  endfunction

  function automatic list_result_t typed_outcome(status_t st, logic [KEY_W-1:0] k,
                                                 logic [VAL_W-1:0] v, int n);
    list_result_t res;
    res        = '0;
    res.status = st;
    res.key    = k;
    res.value  = v;
    res.count  = COUNT_W'(n);
    res.empty  = (n == 0);
    res.full   = (n >= LIST_DEPTH);
    return res;
  endfunction

  task automatic predict_list_op(input list_op_t req, output list_result_t res);
    int          n;
    list_entry_t fresh;
    n          = list_model.size();
    fresh      = '{req.key, req.value};
    res        = '0;
    res.status = ST_OK;
    case (req.op)
      OP_READ, OP_REMOVE: begin
        if (req.op == OP_REMOVE && n == 0) begin
          res.status = ST_EMPTY;
        end else if (req.position >= n) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.key   = list_model[req.position].key;
          res.value = list_model[req.position].value;
          if (req.op == OP_REMOVE) list_model.delete(req.position);
        end
      end
      OP_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < n; i++) begin
          if (res.status == ST_NOT_FOUND && list_model[i].key == req.key) begin
            res.status = ST_OK;
            res.found  = FOUND_W'(i);
          end
        end
      end
      OP_INS_POS, OP_INS_HEAD, OP_INS_TAIL: begin
        if (n >= LIST_DEPTH) res.status = ST_FULL;
        else if (req.op == OP_INS_POS && req.position > n) res.status = ST_BAD_INDEX;
        else if (req.op == OP_INS_HEAD) list_model.push_front(fresh);
        else if (req.op == OP_INS_TAIL) list_model.push_back(fresh);
        else list_model.insert(req.position, fresh);
      end
      default: res.status = ST_BAD_INDEX;
    endcase
    n         = list_model.size();
    res.count = COUNT_W'(n);
    res.empty = (n == 0);
    res.full  = (n >= LIST_DEPTH);
  endtask

  task automatic build_random_op(input traffic_phase_t phase, output list_op_t req);
    int               n;
    int               pick;
    int               cum_weight [7];
    logic [OP_W-1:0]  op_menu [7];
    logic [KEY_W-1:0] corners [4];
    n       = list_model.size();
    op_menu = '{OP_READ, OP_SEARCH, OP_INS_POS, OP_INS_HEAD, OP_INS_TAIL, OP_REMOVE,
                OP_UNUSED_6};
    corners = '{KEY_MIN, KEY_MAX, KEY_ONES, '0};
    case (phase)
      PHASE_FILL:  cum_weight = '{7, 15, 45, 65, 90, 96, 100};
      PHASE_DRAIN: cum_weight = '{10, 18, 24, 26, 28, 96, 100};
      default:     cum_weight = '{18, 38, 53, 61, 69, 96, 100};
    endcase
    pick   = $urandom_range(0, 99);
    req.op = op_menu[6];
    for (int k = 6; k >= 0; k--) begin
      if (pick < cum_weight[k]) req.op = op_menu[k];
    end
    if (req.op == OP_UNUSED_6 && $urandom_range(0, 1) == 1) req.op = OP_UNUSED_7;

    // A slice of the traffic uses any position, in range or not.
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      req.position = POS_W'($urandom_range(0, POS_SPAN));
    end else begin
      case (req.op)
        OP_INS_POS:         req.position = POS_W'($urandom_range(0, n));
        OP_READ, OP_REMOVE: req.position = (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
        default:            req.position = POS_W'($urandom_range(0, POS_SPAN));
      endcase
    end

    // Small keys repeat often, so searches meet duplicates and the lowest match matters.
    pick = $urandom_range(0, 99);
    if (req.op == OP_SEARCH && n > 0 && pick < 60) req.key = list_model[$urandom_range(0, n - 1)].key;
    else if (pick < 45) req.key = KEY_W'($urandom_range(0, 15));
    else if (pick < 55) req.key = corners[$urandom_range(0, 3)];
    else req.key = $urandom;
    req.value = ($urandom_range(0, 9) == 0) ? corners[$urandom_range(0, 3)] : $urandom;
  endtask

  // Valid stays high across back-to-back transactions; it drops only before a gap or while waiting for results.
  task automatic send_op(input list_op_t req, input logic typed, input list_result_t want);
    int           gap;
    list_result_t predicted;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_ch.valid    <= 1'b1;
    op_ch.op       <= req.op;
    op_ch.position <= req.position;
    op_ch.key_in   <= req.key;
    op_ch.value_in <= req.value;
    do @(posedge clk); while (!op_ch.ready);
    predict_list_op(req, predicted);
    predicted_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_for_results();
    op_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  function automatic void flag_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      error_count++;
    end
  endfunction

  task automatic check_result(input list_result_t want);
    results_checked++;
    if (want.full) full_results++;
    if (want.status == ST_FULL) full_refusals++;
    if (want.status == ST_EMPTY) empty_refusals++;
    flag_field("status", 32'(want.status), 32'(res_ch.status));
    flag_field("found_position", 32'(want.found), 32'(res_ch.found_position));
    flag_field("key_out", want.key, res_ch.key_out);
    flag_field("value_out", want.value, res_ch.value_out);
    flag_field("entry_count", 32'(want.count), 32'(res_ch.entry_count));
    flag_field("is_empty", 32'(want.empty), 32'(res_ch.is_empty));
    flag_field("is_full", 32'(want.full), 32'(res_ch.is_full));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual status %h count %0d",
                   $time, res_ch.status, res_ch.entry_count);
          error_count++;
        end else begin
          check_result(predicted_results.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_ordered_array_list_core: done, errors");
      $finish;
    end
  end

  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_wait(recv_quiet);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin
    list_op_t       req;
    traffic_phase_t phase;
    int             steps;
    int             extra;
    int             phase_cap;
    int             random_sent;

    op_ch.valid    <= 1'b0;
    op_ch.op       <= OP_READ;
    op_ch.position <= '0;
    op_ch.key_in   <= '0;
    op_ch.value_in <= '0;

    // After the first head insert the list holds (KEY_MIN, KEY_MAX) then (KEY_MAX, KEY_MIN).
    directed_rows = '{
      '{OP_READ,     7'd0,   32'd0,        32'd0,    1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 0)},
      '{OP_REMOVE,   7'd0,   32'd0,        32'd0,    1'b1, typed_outcome(ST_EMPTY, 0, 0, 0)},
      '{OP_SEARCH,   7'd0,   32'd0,        32'd0,    1'b1, typed_outcome(ST_NOT_FOUND, 0, 0, 0)},
      '{OP_INS_POS,  7'd1,   32'd9,        32'd9,    1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 0)},
      '{OP_INS_POS,  7'd0,   KEY_MAX,      KEY_MIN,  1'b1, typed_outcome(ST_OK, 0, 0, 1)},
      '{OP_INS_HEAD, 7'd0,   KEY_MIN,      KEY_MAX,  1'b1, typed_outcome(ST_OK, 0, 0, 2)},
      '{OP_INS_TAIL, 7'd0,   KEY_ONES,     32'd0,    1'b1, typed_outcome(ST_OK, 0, 0, 3)},
      '{OP_READ,     7'd0,   32'd0,        32'd0,    1'b1, typed_outcome(ST_OK, KEY_MIN, KEY_MAX, 3)},
      '{OP_READ,     7'd2,   32'd0,        32'd0,    1'b1, typed_outcome(ST_OK, KEY_ONES, 0, 3)},
      '{OP_SEARCH,   7'd0,   KEY_ONES,     32'd0,    1'b0, '0},
      '{OP_SEARCH,   7'd0,   KEY_MAX,      32'd0,    1'b0, '0},
      '{OP_SEARCH,   7'd0,   32'h1234_5678, 32'd0,   1'b1, typed_outcome(ST_NOT_FOUND, 0, 0, 3)},
      '{OP_UNUSED_6, 7'd0,   32'd0,        32'd0,    1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 3)},
      '{OP_UNUSED_7, 7'd127, KEY_ONES,     KEY_ONES, 1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 3)},
      '{OP_READ,     7'd127, 32'd0,        32'd0,    1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 3)},
      '{OP_REMOVE,   7'd3,   32'd0,        32'd0,    1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 3)},
      '{OP_INS_POS,  7'd4,   32'd1,        32'd1,    1'b1, typed_outcome(ST_BAD_INDEX, 0, 0, 3)},
      '{OP_INS_POS,  7'd3,   32'd5,        32'd50,   1'b0, '0},
      '{OP_INS_POS,  7'd1,   32'd5,        32'd51,   1'b0, '0},
      '{OP_SEARCH,   7'd0,   32'd5,        32'd0,    1'b0, '0},
      '{OP_REMOVE,   7'd0,   32'd0,        32'd0,    1'b0, '0},
      '{OP_REMOVE,   7'd3,   32'd0,        32'd0,    1'b0, '0},
      '{OP_READ,     7'd1,   32'd0,        32'd0,    1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      req = '{directed_rows[i].op, directed_rows[i].position, directed_rows[i].key,
              directed_rows[i].value};
      send_op(req, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_results();

    // The first phase fills the list so the full cases come early.
    phase       = PHASE_FILL;
    random_sent = 0;
    while (random_sent < RANDOM_OPS) begin
      phase_cap = (phase == PHASE_MIXED) ? 60 : 300;
      steps     = 0;
      extra     = 0;
      while (random_sent < RANDOM_OPS && steps < phase_cap && extra < 6) begin
        build_random_op(phase, req);
        send_op(req, 1'b0, '0);
        random_sent++;
        steps++;
        if ((phase == PHASE_FILL && list_model.size() == LIST_DEPTH) ||
            (phase == PHASE_DRAIN && list_model.size() == 0)) extra++;
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
      case ($urandom_range(0, 2))
        0:       phase = PHASE_FILL;
        1:       phase = PHASE_DRAIN;
        default: phase = PHASE_MIXED;
      endcase
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_results.size());
      error_count++;
    end
    $display("Covered %0d operations, %0d results checked, %0d mismatches.",
             items_sent, results_checked, error_count);
    $display("List at capacity in %0d results; %0d full refusals, %0d empty refusals.",
             full_results, full_refusals, empty_refusals);
    if (error_count == 0) begin
      $display("tb_ordered_array_list_core: done, clean");
    end else begin
      $display("tb_ordered_array_list_core: done, errors");
    end
    $finish;
  end

endmodule
